// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check an implication in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/bvad_pkg.sv
// Shared types and opcodes for the bitvector divide/shift ALU
package bvad_pkg;
    localparam logic [3:0] OP_SHL  = 4'd0;
    localparam logic [3:0] OP_LSHR = 4'd1;
    localparam logic [3:0] OP_ASHR = 4'd2;
    localparam logic [3:0] OP_UDIV = 4'd3;
    localparam logic [3:0] OP_UREM = 4'd4;
    localparam logic [3:0] OP_SDIV = 4'd5;
    localparam logic [3:0] OP_SREM = 4'd6;
    localparam logic [3:0] OP_SMOD = 4'd7;
    localparam logic [3:0] OP_SGE  = 4'd8;
    localparam logic [3:0] OP_SGT  = 4'd9;
    localparam int unsigned DATA_W = 64;

    // Per-item control carried down the pipe
    typedef struct packed {
        logic [3:0]        op;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] a;      // masked operand a
        logic [DATA_W-1:0] b;      // masked operand b
        logic              na;
        logic              nb;
        logic              bzero;
        logic [DATA_W-1:0] fast;   // result of shifts, compares, unused ops
    } t_ctl;
endpackage

// File: hw/rtl/bvad_if.sv
// Valid/ready channel interfaces for the ALU
interface bvad_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [6:0]  width;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    modport source (output valid, op, width, operand_a, operand_b, input ready);
    modport sink   (input valid, op, width, operand_a, operand_b, output ready);
endinterface

interface bvad_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

// File: hw/rtl/bvad_front.sv
// Front stage: width clamp, operand masking, shifts and compares
module bvad_front #(
    parameter int unsigned MAX_WIDTH = 64
) (
    input  logic [3:0]               i_op,
    input  logic [6:0]               i_width,
    input  logic [63:0]              i_a,
    input  logic [63:0]              i_b,
    output bvad_pkg::t_ctl           o_ctl
);
    logic [6:0]  w_n;
    logic [63:0] w_m, w_a, w_b, w_sgn, w_sa, w_sh;
    logic        w_big;
    logic [5:0]  w_s;

    always_comb begin
        w_n = i_width;
        if (w_n == 7'd0) w_n = 7'd1;
        if (w_n > 7'(MAX_WIDTH)) w_n = 7'(MAX_WIDTH);
        w_m   = (w_n >= 7'd64) ? '1 : ((64'd1 << w_n[5:0]) - 64'd1);
        w_a   = i_a & w_m;
        w_b   = i_b & w_m;
        w_sgn = 64'd1 << (w_n[5:0] - 6'd1);
        w_sa  = ((w_a & w_sgn) != 0) ? (w_a | ~w_m) : w_a;
        w_big = w_b >= {57'd0, w_n};
        w_s   = w_b[5:0];
        o_ctl.op     = i_op;
        o_ctl.mask   = w_m;
        o_ctl.a      = w_a;
        o_ctl.b      = w_b;
        o_ctl.na     = (w_a & w_sgn) != 0;
        o_ctl.nb     = (w_b & w_sgn) != 0;
        o_ctl.bzero  = (w_b == 64'd0);
        case (i_op)
            bvad_pkg::OP_SHL:  w_sh = w_big ? 64'd0 : (w_a << w_s);
            bvad_pkg::OP_LSHR: w_sh = w_big ? 64'd0 : (w_a >> w_s);
            bvad_pkg::OP_ASHR: w_sh = w_big ? (o_ctl.na ? w_m : 64'd0)
                                            : 64'($signed(w_sa) >>> w_s);
            bvad_pkg::OP_SGE:  w_sh = {63'd0, (w_a ^ w_sgn) >= (w_b ^ w_sgn)};
            bvad_pkg::OP_SGT:  w_sh = {63'd0, (w_a ^ w_sgn) > (w_b ^ w_sgn)};
            default:           w_sh = 64'd0;
        endcase
        o_ctl.fast = w_sh & w_m;
    end
endmodule

// File: hw/rtl/bvad_div_stage.sv
// One pipeline stage of restoring division: BPS quotient bits per stage
module bvad_div_stage #(
    parameter int unsigned BPS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_rem,
    input  logic [63:0] i_quo,   // remaining dividend bits shift out of the top
    input  logic [63:0] i_div,
    input  bvad_pkg::t_ctl i_ctl,
    output logic        o_valid,
    output logic [63:0] o_rem,
    output logic [63:0] o_quo,
    output logic [63:0] o_div,
    output bvad_pkg::t_ctl o_ctl
);
    logic [63:0] n_rem, n_quo;
    logic [64:0] w_t;
    logic        r_valid;
    logic [63:0] r_rem, r_quo, r_div;
    bvad_pkg::t_ctl r_ctl;

    always_comb begin
        n_rem = i_rem;
        n_quo = i_quo;
        for (int k = 0; k < BPS; k++) begin
            w_t   = {n_rem, n_quo[63]};
            n_quo = {n_quo[62:0], 1'b0};
            if (w_t >= {1'b0, i_div}) begin
                w_t      = w_t - {1'b0, i_div};
                n_quo[0] = 1'b1;
            end
            n_rem = w_t[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_div <= i_div;
            r_ctl <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_ctl   = r_ctl;
endmodule

// File: hw/rtl/bitvector_alu_div_shift.sv
// Top level: pipelined bitvector shift/divide/compare ALU
//  channel  | dir | fields
//  s_in     | in  | op, width, operand_a, operand_b
//  m_out    | out | result
// One item per cycle while the output is not stalled; the pipe is the front
// register, 16 divider stages of 4 bits, sign fixup and output register. The pipe advances while the output
// register is empty or taken; a stall freezes every stage in place.
// Reset clears all valid bits; payload registers are not reset.
`include "assert_macros.svh"
module bitvector_alu_div_shift #(
    parameter int unsigned MAX_WIDTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bvad_in_if.sink    s_in,
    bvad_out_if.source m_out
);
    localparam int unsigned BPS = 4;
    localparam int unsigned NST = 64 / BPS;

    logic w_en;
    bvad_pkg::t_ctl w_fctl;
    logic r_v0;
    bvad_pkg::t_ctl r_c0;
    logic [63:0] r_ma, r_mb;

    logic        st_v [NST+1];
    logic [63:0] st_r [NST+1];
    logic [63:0] st_q [NST+1];
    logic [63:0] st_d [NST+1];
    bvad_pkg::t_ctl st_c [NST+1];

    logic        r_v2;
    logic [63:0] r_res;
    logic        r_ov;
    logic [63:0] r_out;
    logic [63:0] n_res;

    assign w_en       = !r_ov || m_out.ready;
    assign s_in.ready = w_en;

    bvad_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_op(s_in.op), .i_width(s_in.width), .i_a(s_in.operand_a),
        .i_b(s_in.operand_b), .o_ctl(w_fctl)
    );

    // Stage 0: register front results plus operand magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= s_in.valid;
        end
        if (w_en) begin
            r_c0 <= w_fctl;
            if (w_fctl.op == bvad_pkg::OP_UDIV || w_fctl.op == bvad_pkg::OP_UREM) begin
                r_ma <= w_fctl.a;
                r_mb <= w_fctl.b;
            end else begin
                r_ma <= w_fctl.na ? ((~w_fctl.a + 64'd1) & w_fctl.mask) : w_fctl.a;
                r_mb <= w_fctl.nb ? ((~w_fctl.b + 64'd1) & w_fctl.mask) : w_fctl.b;
            end
        end
    end

    assign st_v[0] = r_v0;
    assign st_r[0] = 64'd0;
    assign st_q[0] = r_ma;
    assign st_d[0] = r_mb;
    assign st_c[0] = r_c0;

    for (genvar g = 0; g < NST; g++) begin : g_div
        bvad_div_stage #(.BPS(BPS)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(st_v[g]), .i_rem(st_r[g]), .i_quo(st_q[g]),
            .i_div(st_d[g]), .i_ctl(st_c[g]),
            .o_valid(st_v[g+1]), .o_rem(st_r[g+1]), .o_quo(st_q[g+1]),
            .o_div(st_d[g+1]), .o_ctl(st_c[g+1])
        );
    end

    // Sign fixup and SMT-LIB division-by-zero rules
    always_comb begin
        bvad_pkg::t_ctl c;
        logic [63:0] q, rm, rs;
        c  = st_c[NST];
        q  = st_q[NST];
        rm = st_r[NST];
        rs = c.na ? (~rm + 64'd1) : rm;
        case (c.op)
            bvad_pkg::OP_UDIV: n_res = c.bzero ? c.mask : q;
            bvad_pkg::OP_UREM: n_res = c.bzero ? c.a : rm;
            bvad_pkg::OP_SDIV: n_res = c.bzero ? (c.na ? 64'd1 : '1)
                                     : ((c.na != c.nb) ? (~q + 64'd1) : q);
            bvad_pkg::OP_SREM: n_res = c.bzero ? c.a : rs;
            bvad_pkg::OP_SMOD: n_res = c.bzero ? c.a
                                     : ((rm != 0 && c.na != c.nb) ? (rs + c.b) : rs);
            default:           n_res = c.fast;
        endcase
        n_res = n_res & c.mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v2 <= st_v[NST];
            r_ov <= r_v2;
        end
        if (w_en) begin
            r_res <= n_res;
            r_out <= r_res;
        end
    end

    assign m_out.valid  = r_ov;
    assign m_out.result = r_out;

    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_ov && !m_out.ready, r_ov && $stable(r_out))
    `ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !r_ov, s_in.ready)
    `ASSERT_NEXT(a_adv, i_clk, i_rst_n, w_en && r_v2, r_ov)
endmodule
